// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, removable with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/tonq_pkg.sv =====
// ----------------------------------------------------------------------------
// tonq_pkg
// codes, types and the q-method update function of the option negotiator
// ----------------------------------------------------------------------------
package tonq_pkg;

  // default number of options kept per side
  localparam int OptionCount = 256;

  // operation codes
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RECEIVE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  // q-method states
  localparam logic [1:0] Q_NO      = 2'd0;
  localparam logic [1:0] Q_YES     = 2'd1;
  localparam logic [1:0] Q_WANTNO  = 2'd2;
  localparam logic [1:0] Q_WANTYES = 2'd3;

  // command bytes
  localparam logic [7:0] CMD_WILL = 8'd251;
  localparam logic [7:0] CMD_WONT = 8'd252;
  localparam logic [7:0] CMD_DO   = 8'd253;
  localparam logic [7:0] CMD_DONT = 8'd254;

  // one side of an option: queue bit over the state
  typedef struct packed {
    logic       queued;
    logic [1:0] state;
  } q_entry_t;

  // outcome of one update
  typedef struct packed {
    q_entry_t   entry;
    logic       send;
    logic [7:0] cmd;
  } q_result_t;

  // one q-method step for a request, a positive or a negative command
  function automatic q_result_t q_next(q_entry_t e, logic dir, logic is_req,
                                       logic en, logic pos, logic acc);
    q_result_t  r;
    logic [7:0] cmd_on;
    logic [7:0] cmd_off;
    cmd_on  = dir ? CMD_DO : CMD_WILL;
    cmd_off = dir ? CMD_DONT : CMD_WONT;
    r.entry = e;
    r.send  = 1'b0;
    r.cmd   = 8'd0;
    if (is_req) begin
      if (en) begin
        unique case (e.state)
          Q_NO: begin
            r.entry = '{queued: 1'b0, state: Q_WANTYES};
            r.send  = 1'b1;
            r.cmd   = cmd_on;
          end
          Q_WANTNO:  r.entry = '{queued: 1'b1, state: Q_WANTNO};
          Q_WANTYES: r.entry = '{queued: 1'b0, state: Q_WANTYES};
          default:   r.entry = e;
        endcase
      end else begin
        unique case (e.state)
          Q_YES: begin
            r.entry = '{queued: 1'b0, state: Q_WANTNO};
            r.send  = 1'b1;
            r.cmd   = cmd_off;
          end
          Q_WANTNO:  r.entry = '{queued: 1'b0, state: Q_WANTNO};
          Q_WANTYES: r.entry = '{queued: 1'b1, state: Q_WANTYES};
          default:   r.entry = e;
        endcase
      end
    end else if (pos) begin
      unique case (e.state)
        Q_NO: begin
          r.send = 1'b1;
          if (acc) begin
            r.entry = '{queued: 1'b0, state: Q_YES};
            r.cmd   = cmd_on;
          end else begin
            r.cmd = cmd_off;
          end
        end
        Q_YES:    r.entry = e;
        Q_WANTNO: r.entry = '{queued: 1'b0, state: (e.queued ? Q_YES : Q_NO)};
        default: begin
          if (e.queued) begin
            r.entry = '{queued: 1'b0, state: Q_WANTNO};
            r.send  = 1'b1;
            r.cmd   = cmd_off;
          end else begin
            r.entry = '{queued: 1'b0, state: Q_YES};
          end
        end
      endcase
    end else begin
      unique case (e.state)
        Q_NO: r.entry = e;
        Q_YES: begin
          r.entry = '{queued: 1'b0, state: Q_NO};
          r.send  = 1'b1;
          r.cmd   = cmd_off;
        end
        Q_WANTNO: begin
          if (e.queued) begin
            r.entry = '{queued: 1'b0, state: Q_WANTYES};
            r.send  = 1'b1;
            r.cmd   = cmd_on;
          end else begin
            r.entry = '{queued: 1'b0, state: Q_NO};
          end
        end
        default: r.entry = '{queued: 1'b0, state: Q_NO};
      endcase
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/telnet_option_q_negotiator.sv =====
// ----------------------------------------------------------------------------
// telnet_option_q_negotiator
// q-method option negotiation table for both sides of a telnet session
// ----------------------------------------------------------------------------
// Takes one item per clock while not stalled and returns one result item for
// each through the stage 1 and result registers. The option table lives in
// a single-port-write RAM, one row per option holding the local and remote
// entries; its registered read feeds one update stage that writes the row
// back, with the write of the previous item forwarded into the next read so
// back-to-back items on the same option see each other. A valid bit per row
// makes a never-written row read as NO with an empty queue, so no clearing
// pass runs after reset and items are taken from the first cycle.
`include "assert_macros.svh"

module telnet_option_q_negotiator #(
  parameter int OPTION_COUNT = tonq_pkg::OptionCount
) (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic       direction,
  input  logic [7:0] option,
  input  logic       enable,
  input  logic [7:0] command,
  input  logic       peer_accepts,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       send_valid,
  output logic [7:0] send_command,
  output logic [7:0] send_option,
  output logic       enabled
);

  localparam int RowAw = (OPTION_COUNT > 1) ? $clog2(OPTION_COUNT) : 1;

  // pipeline advance and input handshake
  logic adv;
  logic in_accept;
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign in_accept = in_valid && adv;

  logic [RowAw-1:0] in_row;
  assign in_row = option[RowAw-1:0];

  // option table: local entry in the low half of a row, remote in the high
  logic [5:0]       mem [OPTION_COUNT];
  logic             row_vld [OPTION_COUNT];
  logic [5:0]       rd_data;
  logic             rd_vld;
  logic             fwd_hit;
  logic [5:0]       fwd_data;
  logic             wr_en;
  logic [RowAw-1:0] wr_row;
  logic [5:0]       wr_data;

  // stage 1 item registers
  logic       s1_valid;
  logic [1:0] s1_op;
  logic       s1_dir;
  logic [7:0] s1_opt;
  logic       s1_en;
  logic [7:0] s1_cmd;
  logic       s1_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op  <= operation;
      s1_dir <= direction;
      s1_opt <= option;
      s1_en  <= enable;
      s1_cmd <= command;
      s1_acc <= peer_accepts;
    end
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (adv) begin
      rd_data <= mem[in_row];
    end
  end

  // row valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < OPTION_COUNT; i++) begin
        row_vld[i] <= 1'b0;
      end
    end else if (wr_en) begin
      row_vld[wr_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_vld <= row_vld[in_row];
    end
  end

  // forward a write that lands on the row being read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (adv) begin
      fwd_hit <= in_accept && wr_en && (wr_row == in_row);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_data <= wr_data;
    end
  end

  // update stage
  logic                s1_in_range;
  logic                cmd_known;
  logic                cmd_remote;
  logic                cmd_pos;
  logic                side;
  logic [5:0]          row;
  tonq_pkg::q_entry_t  cur;
  tonq_pkg::q_result_t res;
  logic                does_write;

  always_comb begin
    s1_in_range = ({1'b0, s1_opt} < 9'(OPTION_COUNT));
    cmd_known   = (s1_cmd == tonq_pkg::CMD_WILL) || (s1_cmd == tonq_pkg::CMD_WONT) ||
                  (s1_cmd == tonq_pkg::CMD_DO) || (s1_cmd == tonq_pkg::CMD_DONT);
    cmd_remote  = (s1_cmd == tonq_pkg::CMD_WILL) || (s1_cmd == tonq_pkg::CMD_WONT);
    cmd_pos     = (s1_cmd == tonq_pkg::CMD_WILL) || (s1_cmd == tonq_pkg::CMD_DO);
    side        = (s1_op == tonq_pkg::OP_RECEIVE) ? cmd_remote : s1_dir;
    if (fwd_hit) begin
      row = fwd_data;
    end else if (rd_vld) begin
      row = rd_data;
    end else begin
      row = '0;
    end
    cur = side ? row[5:3] : row[2:0];
    res = tonq_pkg::q_next(cur, side, (s1_op == tonq_pkg::OP_REQUEST), s1_en,
                           cmd_pos, s1_acc);
    does_write = s1_in_range && ((s1_op == tonq_pkg::OP_REQUEST) ||
                                 ((s1_op == tonq_pkg::OP_RECEIVE) && cmd_known));
    wr_en   = s1_valid && adv && does_write;
    wr_row  = s1_opt[RowAw-1:0];
    wr_data = side ? {res.entry, row[2:0]} : {row[5:3], res.entry};
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      send_valid   <= does_write && res.send;
      send_command <= (does_write && res.send) ? res.cmd : 8'd0;
      send_option  <= (does_write && res.send) ? s1_opt : 8'd0;
      enabled      <= s1_in_range && (s1_op == tonq_pkg::OP_QUERY) &&
                      (cur.state == tonq_pkg::Q_YES);
    end
  end

  // terms for the checks
  logic chk_send_code;
  logic chk_idle_fields;
  logic chk_fwd;
  assign chk_send_code   = (send_command == tonq_pkg::CMD_WILL) ||
                           (send_command == tonq_pkg::CMD_WONT) ||
                           (send_command == tonq_pkg::CMD_DO) ||
                           (send_command == tonq_pkg::CMD_DONT);
  assign chk_idle_fields = (send_command == 8'd0) && (send_option == 8'd0);
  assign chk_fwd         = wr_en && in_accept && (wr_row == in_row);

  // checks
  `ASSERT_IMPLY(a_send_code, clk, rst, out_valid && send_valid, chk_send_code)
  `ASSERT_IMPLY(a_query_no_send, clk, rst, out_valid && enabled, !send_valid)
  `ASSERT_IMPLY(a_idle_fields, clk, rst, out_valid && !send_valid, chk_idle_fields)
  `ASSERT_NEXT(a_forward, clk, rst, chk_fwd, fwd_hit && (fwd_data == $past(wr_data)))

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the telnet option q-method negotiator. Items go in
// from a pending queue on a valid/stall channel with random gaps. Each
// accepted item runs through a local q-method table model. The model's reply
// is queued and compared field by field with the result items as they are
// taken, under random output stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int OPTION_COUNT = tonq_pkg::OptionCount;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1926;
  localparam int HOT_COUNT = 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [1:0] operation;
    logic       direction;
    logic [7:0] option;
    logic       enable;
    logic [7:0] command;
    logic       peer_accepts;
    logic       hold;
  } nego_item_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_command;
    logic [7:0] send_option;
    logic       enabled;
  } reply_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] operation = '0;
  logic       direction = 1'b0;
  logic [7:0] option = '0;
  logic       enable = 1'b0;
  logic [7:0] command = '0;
  logic       peer_accepts = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       send_valid;
  logic [7:0] send_command;
  logic [7:0] send_option;
  logic       enabled;

  nego_item_t         pending_items[$];
  reply_t             reply_exp[$];
  tonq_pkg::q_entry_t opt_table[2][OPTION_COUNT] = '{default: '0};
  logic [7:0]         hot_options[HOT_COUNT];
  nego_item_t         next_item;

  int errors = 0;
  int items_total = 0;
  int items_accepted = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int cycle_count = 0;
  bit in_taken = 1'b0;
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;

  telnet_option_q_negotiator #(
    .OPTION_COUNT(OPTION_COUNT)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .direction   (direction),
    .option      (option),
    .enable      (enable),
    .command     (command),
    .peer_accepts(peer_accepts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .send_valid  (send_valid),
    .send_command(send_command),
    .send_option (send_option),
    .enabled     (enabled)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // q-method table update for one item, returns the reply it causes
  function automatic reply_t negotiate(logic [1:0] op, logic dir, logic [7:0] opt,
                                       logic en, logic [7:0] cmd, logic acc);
    reply_t             r;
    tonq_pkg::q_entry_t e;
    logic               side;
    logic               positive;
    logic [7:0]         cmd_on;
    logic [7:0]         cmd_off;
    r = '0;
    if (int'(opt) >= OPTION_COUNT) return r;
    if (op == tonq_pkg::OP_QUERY) begin
      r.enabled = (opt_table[dir][opt].state == tonq_pkg::Q_YES);
      return r;
    end
    // the side comes from the direction field or from the command byte
    if (op == tonq_pkg::OP_REQUEST) begin
      side = dir;
    end else if (op == tonq_pkg::OP_RECEIVE && cmd >= tonq_pkg::CMD_WILL &&
                 cmd <= tonq_pkg::CMD_DONT) begin
      side = (cmd == tonq_pkg::CMD_WILL || cmd == tonq_pkg::CMD_WONT);
    end else begin
      return r;
    end
    e        = opt_table[side][opt];
    cmd_on   = side ? tonq_pkg::CMD_DO : tonq_pkg::CMD_WILL;
    cmd_off  = side ? tonq_pkg::CMD_DONT : tonq_pkg::CMD_WONT;
    positive = (cmd == tonq_pkg::CMD_WILL || cmd == tonq_pkg::CMD_DO);
    if (op == tonq_pkg::OP_REQUEST && en) begin
      // local wish to turn the option on
      case (e.state)
        tonq_pkg::Q_NO: begin
          e = '{1'b0, tonq_pkg::Q_WANTYES};
          r.send_command = cmd_on;
        end
        tonq_pkg::Q_WANTNO:  e.queued = 1'b1;
        tonq_pkg::Q_WANTYES: e.queued = 1'b0;
        default: ;
      endcase
    end else if (op == tonq_pkg::OP_REQUEST) begin
      // local wish to turn the option off
      case (e.state)
        tonq_pkg::Q_YES: begin
          e = '{1'b0, tonq_pkg::Q_WANTNO};
          r.send_command = cmd_off;
        end
        tonq_pkg::Q_WANTNO:  e.queued = 1'b0;
        tonq_pkg::Q_WANTYES: e.queued = 1'b1;
        default: ;
      endcase
    end else if (positive) begin
      // peer offers or asks for the option
      case (e.state)
        tonq_pkg::Q_NO: begin
          if (acc) e = '{1'b0, tonq_pkg::Q_YES};
          r.send_command = acc ? cmd_on : cmd_off;
        end
        tonq_pkg::Q_WANTNO: e = '{1'b0, (e.queued ? tonq_pkg::Q_YES : tonq_pkg::Q_NO)};
        tonq_pkg::Q_WANTYES: begin
          if (e.queued) begin
            e = '{1'b0, tonq_pkg::Q_WANTNO};
            r.send_command = cmd_off;
          end else begin
            e = '{1'b0, tonq_pkg::Q_YES};
          end
        end
        default: ;
      endcase
    end else begin
      // peer refuses or drops the option
      case (e.state)
        tonq_pkg::Q_YES: begin
          e = '{1'b0, tonq_pkg::Q_NO};
          r.send_command = cmd_off;
        end
        tonq_pkg::Q_WANTNO: begin
          if (e.queued) begin
            e = '{1'b0, tonq_pkg::Q_WANTYES};
            r.send_command = cmd_on;
          end else begin
            e = '{1'b0, tonq_pkg::Q_NO};
          end
        end
        tonq_pkg::Q_WANTYES: e = '{1'b0, tonq_pkg::Q_NO};
        default: ;
      endcase
    end
    opt_table[side][opt] = e;
    r.send_valid = (r.send_command != 8'd0);
    if (r.send_valid) r.send_option = opt;
    return r;
  endfunction

  task automatic push_item(logic [1:0] op, logic dir, logic [7:0] opt, logic en,
                           logic [7:0] cmd, logic acc);
    pending_items.push_back('{op, dir, opt, en, cmd, acc, 1'b0});
  endtask

  // random item: mostly a few busy options so entries walk through all states
  function automatic nego_item_t random_item();
    nego_item_t it;
    int         roll;
    it.direction    = 1'($urandom_range(0, 1));
    it.enable       = 1'($urandom_range(0, 1));
    it.peer_accepts = 1'($urandom_range(0, 1));
    it.command      = 8'($urandom_range(0, 255));
    it.hold         = 1'b0;
    if ($urandom_range(0, 99) < 75) begin
      it.option = hot_options[$urandom_range(0, HOT_COUNT - 1)];
    end else begin
      it.option = 8'($urandom_range(0, 255));
    end
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      it.operation = tonq_pkg::OP_REQUEST;
    end else if (roll < 80) begin
      it.operation = tonq_pkg::OP_RECEIVE;
      if ($urandom_range(0, 9) != 0) begin
        it.command = 8'(tonq_pkg::CMD_WILL + $urandom_range(0, 3));
      end
    end else if (roll < 96) begin
      it.operation = tonq_pkg::OP_QUERY;
    end else begin
      it.operation = OP_UNUSED;
    end
    return it;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
  endtask

  task automatic check_reply();
    reply_t want;
    if (reply_exp.size() == 0) begin
      report_mismatch("result item with nothing expected", 1, 0);
      return;
    end
    want = reply_exp.pop_front();
    if (send_valid !== want.send_valid)
      report_mismatch("send_valid", int'(send_valid), int'(want.send_valid));
    if (send_command !== want.send_command)
      report_mismatch("send_command", int'(send_command), int'(want.send_command));
    if (send_option !== want.send_option)
      report_mismatch("send_option", int'(send_option), int'(want.send_option));
    if (enabled !== want.enabled)
      report_mismatch("enabled", int'(enabled), int'(want.enabled));
  endtask

  // calm stretches with no idling on either side
  always @(negedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 300 == 0) begin
      calm_in  <= ($urandom_range(0, 3) == 0);
      calm_out <= ($urandom_range(0, 3) == 0);
    end
  end

  // item driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() == 0 ||
                   (pending_items[0].hold && reply_exp.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        next_item = pending_items.pop_front();
        operation    <= next_item.operation;
        direction    <= next_item.direction;
        option       <= next_item.option;
        enable       <= next_item.enable;
        command      <= next_item.command;
        peer_accepts <= next_item.peer_accepts;
        in_valid     <= 1'b1;
        gap_left     <= calm_in ? 0 : pick_gap();
      end
    end
  end

  // result stall
  always @(negedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= calm_out ? 0 : pick_gap();
    end
  end

  // monitor: predict on input accept, check on result accept
  always @(posedge clk) begin
    if (rst) begin
      in_taken    <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        reply_exp.push_back(negotiate(operation, direction, option, enable,
                                      command, peer_accepts));
        items_accepted++;
      end
      if (out_valid && !out_stall) check_reply();
      idle_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ?
                     0 : idle_cycles + 1;
    end
  end

  // watchdog
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // stimulus and end of run
  initial begin
    nego_item_t rand_item;
    hot_options[0] = 8'd0;
    hot_options[1] = 8'd255;
    for (int i = 2; i < HOT_COUNT; i++) hot_options[i] = 8'($urandom_range(0, 255));

    // local side of option 255 through every state and the queue bit
    push_item(tonq_pkg::OP_REQUEST, 1'b0, 8'd255, 1'b1, 8'd0, 1'b0);
    push_item(tonq_pkg::OP_REQUEST, 1'b0, 8'd255, 1'b1, 8'd255, 1'b1);
    push_item(tonq_pkg::OP_REQUEST, 1'b0, 8'd255, 1'b0, 8'd0, 1'b0);
    push_item(tonq_pkg::OP_RECEIVE, 1'b1, 8'd255, 1'b0, tonq_pkg::CMD_DO, 1'b1);
    push_item(tonq_pkg::OP_REQUEST, 1'b0, 8'd255, 1'b1, 8'd0, 1'b0);
    push_item(tonq_pkg::OP_RECEIVE, 1'b1, 8'd255, 1'b1, tonq_pkg::CMD_DONT, 1'b0);
    push_item(tonq_pkg::OP_RECEIVE, 1'b1, 8'd255, 1'b1, tonq_pkg::CMD_DO, 1'b0);
    push_item(tonq_pkg::OP_QUERY, 1'b0, 8'd255, 1'b0, 8'd0, 1'b0);
    push_item(tonq_pkg::OP_REQUEST, 1'b0, 8'd255, 1'b1, 8'd0, 1'b1);
    push_item(tonq_pkg::OP_REQUEST, 1'b0, 8'd255, 1'b0, 8'd0, 1'b0);
    push_item(tonq_pkg::OP_REQUEST, 1'b0, 8'd255, 1'b0, 8'd0, 1'b0);
    push_item(tonq_pkg::OP_RECEIVE, 1'b0, 8'd255, 1'b1, tonq_pkg::CMD_DONT, 1'b1);
    // remote side of option 0: refused and granted offers
    push_item(tonq_pkg::OP_RECEIVE, 1'b0, 8'd0, 1'b1, tonq_pkg::CMD_WILL, 1'b0);
    push_item(tonq_pkg::OP_RECEIVE, 1'b0, 8'd0, 1'b0, tonq_pkg::CMD_WILL, 1'b1);
    push_item(tonq_pkg::OP_QUERY, 1'b1, 8'd0, 1'b1, 8'd255, 1'b1);
    push_item(tonq_pkg::OP_RECEIVE, 1'b0, 8'd0, 1'b1, tonq_pkg::CMD_WONT, 1'b1);
    push_item(tonq_pkg::OP_RECEIVE, 1'b1, 8'd0, 1'b0, tonq_pkg::CMD_WONT, 1'b0);
    push_item(tonq_pkg::OP_REQUEST, 1'b1, 8'd0, 1'b1, 8'd0, 1'b0);
    push_item(tonq_pkg::OP_RECEIVE, 1'b1, 8'd0, 1'b1, tonq_pkg::CMD_WONT, 1'b1);
    push_item(tonq_pkg::OP_REQUEST, 1'b1, 8'd0, 1'b0, 8'd0, 1'b0);
    // ignored command bytes, unused operation, query of an idle entry
    push_item(tonq_pkg::OP_RECEIVE, 1'b1, 8'd0, 1'b1, 8'd0, 1'b1);
    push_item(tonq_pkg::OP_RECEIVE, 1'b0, 8'd255, 1'b1, 8'd255, 1'b1);
    push_item(tonq_pkg::OP_RECEIVE, 1'b1, 8'd7, 1'b0, 8'd250, 1'b1);
    push_item(OP_UNUSED, 1'b1, 8'd255, 1'b1, tonq_pkg::CMD_WILL, 1'b1);
    push_item(tonq_pkg::OP_QUERY, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0);

    // random part, draining all results now and then before going on
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      rand_item = random_item();
      rand_item.hold = (n == 0 || n == 700 || n == 1400);
      pending_items.push_back(rand_item);
    end
    items_total = pending_items.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (items_accepted < items_total || reply_exp.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
